@@ hdl/hill_2x2_decrypt_stream_unit_macros.svh @@
// Assertion macros used by the port-level checking module of the Hill decryption stream unit.
`ifndef HILL_2X2_DECRYPT_STREAM_UNIT_MACROS_SVH
`define HILL_2X2_DECRYPT_STREAM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HILL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HILL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/hill_pkg.sv @@
// Shared types and constants of the Hill decryption stream unit.
package hill_pkg;

  localparam int ALPHABET_MAX = 256;
  localparam int SYM_W = 8;
  localparam int MOD_W = 9;
  localparam int CP_W = 21;
  localparam int PROD_W = 2 * SYM_W;
  localparam int DIVIDEND_W = PROD_W + 1;
  localparam int DIV_STEPS = DIVIDEND_W;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = MOD_W;

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(26);
  localparam logic [SYM_W-1:0] KEY_A_RESET = SYM_W'(1);
  localparam logic [SYM_W-1:0] KEY_B_RESET = SYM_W'(0);
  localparam logic [SYM_W-1:0] KEY_C_RESET = SYM_W'(0);
  localparam logic [SYM_W-1:0] KEY_D_RESET = SYM_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS   = 3'd0,
    CFG_INV_KEY_A = 3'd1,
    CFG_INV_KEY_B = 3'd2,
    CFG_INV_KEY_C = 3'd3,
    CFG_INV_KEY_D = 3'd4
  } cfg_index_t;

  typedef enum logic {
    CMD_SYMBOL = 1'b0,
    CMD_FLUSH  = 1'b1
  } command_t;

  typedef enum logic {
    OP_PASS = 1'b0,
    OP_PAIR = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [SYM_W-1:0]     x0;
    logic [SYM_W-1:0]     x1;
    logic [CP_W-1:0]      codepoint;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_req_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_DIV,
    S_EMIT0,
    S_EMIT1,
    S_PASS
  } back_state_t;

endpackage

@@ hdl/hill_2x2_decrypt_stream_unit.sv @@
// Top level of the streaming 2x2 Hill cipher decryption unit.
// The input side takes one item per cycle as long as the two-entry work queue
// has room; a lone symbol or a flush with nothing pending never enters the
// queue. A passthrough symbol occupies the back end for its dequeue and one
// result. A complete pair passes through dequeue, product, sum, 17 steps of the
// bit-serial remainder unit that reduces both sums modulo the alphabet size in
// parallel, then its two results. The back end takes no new item until it is
// through with the last one. Results leave through a valid and ready channel,
// and the back end waits while a result is not taken. Configuration writes are
// always ready and take effect on the next cycle.
module hill_2x2_decrypt_stream_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               command,
  input  logic                               in_alphabet,
  input  logic [hill_pkg::SYM_W-1:0]         symbol_index,
  input  logic [hill_pkg::CP_W-1:0]          raw_codepoint,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               is_passthrough,
  output logic [hill_pkg::SYM_W-1:0]         plain_index,
  output logic [hill_pkg::CP_W-1:0]          plain_codepoint,
  output logic                               last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hill_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hill_pkg::CFG_DATA_W-1:0]    cfg_data
);

  hill_pkg::op_req_t    push;
  hill_pkg::op_req_t    head;
  hill_pkg::cfg_write_t cfg;
  logic                 queue_full;
  logic                 pop;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  hill_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .in_alphabet  (in_alphabet),
    .symbol_index (symbol_index),
    .raw_codepoint(raw_codepoint),
    .queue_full   (queue_full),
    .push         (push)
  );

  hill_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  hill_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_passthrough (is_passthrough),
    .plain_index    (plain_index),
    .plain_codepoint(plain_codepoint),
    .last           (last)
  );

endmodule

@@ hdl/hill_front.sv @@
// Front end: accepts items, pairs alphabet symbols and queues the work.
module hill_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic                          in_alphabet,
  input  logic [hill_pkg::SYM_W-1:0]    symbol_index,
  input  logic [hill_pkg::CP_W-1:0]     raw_codepoint,
  input  logic                          queue_full,
  output hill_pkg::op_req_t             push
);

  logic                       holding;
  logic                       holding_next;
  logic [hill_pkg::SYM_W-1:0] held_symbol;
  logic [hill_pkg::SYM_W-1:0] held_symbol_next;
  logic                       accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    holding_next     = holding;
    held_symbol_next = held_symbol;
    push.valid          = 1'b0;
    push.op.kind        = hill_pkg::OP_PAIR;
    push.op.x0          = held_symbol;
    push.op.x1          = '0;
    push.op.codepoint   = '0;
    if (accept) begin
      priority if (command == hill_pkg::CMD_FLUSH) begin
        if (holding) begin
          push.valid   = 1'b1;
          holding_next = 1'b0;
        end
      end else if (!in_alphabet) begin
        push.valid        = 1'b1;
        push.op.kind      = hill_pkg::OP_PASS;
        push.op.x0        = '0;
        push.op.codepoint = raw_codepoint;
      end else if (!holding) begin
        held_symbol_next = symbol_index;
        holding_next     = 1'b1;
      end else begin
        push.valid   = 1'b1;
        push.op.x1   = symbol_index;
        holding_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding     <= 1'b0;
      held_symbol <= '0;
    end else begin
      holding     <= holding_next;
      held_symbol <= held_symbol_next;
    end
  end

endmodule

@@ hdl/hill_queue.sv @@
// Short work queue between the front end and the arithmetic back end.
module hill_queue (
  input  logic              clk,
  input  logic              rst,
  input  hill_pkg::op_req_t push,
  output logic              full,
  output hill_pkg::op_req_t head,
  input  logic              pop
);

  localparam int PTR_W = (hill_pkg::QUEUE_DEPTH > 1) ? $clog2(hill_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(hill_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(hill_pkg::QUEUE_DEPTH - 1);

  hill_pkg::op_t    entries [hill_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(hill_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.op    = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/hill_back.sv @@
// Back end: key registers, products, bit-serial remainder and result sequencing.
module hill_back (
  input  logic                          clk,
  input  logic                          rst,
  input  hill_pkg::cfg_write_t          cfg,
  input  hill_pkg::op_req_t             head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_passthrough,
  output logic [hill_pkg::SYM_W-1:0]    plain_index,
  output logic [hill_pkg::CP_W-1:0]     plain_codepoint,
  output logic                          last
);

  localparam int SYM_W = hill_pkg::SYM_W;
  localparam int MOD_W = hill_pkg::MOD_W;
  localparam int PROD_W = hill_pkg::PROD_W;
  localparam int DIVIDEND_W = hill_pkg::DIVIDEND_W;
  localparam int STEP_W = hill_pkg::STEP_W;

  logic [MOD_W-1:0] modulus;
  logic [SYM_W-1:0] key_a;
  logic [SYM_W-1:0] key_b;
  logic [SYM_W-1:0] key_c;
  logic [SYM_W-1:0] key_d;
  logic [MOD_W-1:0] eff_mod;

  hill_pkg::back_state_t state;
  hill_pkg::back_state_t state_next;

  logic [SYM_W-1:0]         x0;
  logic [SYM_W-1:0]         x1;
  logic [hill_pkg::CP_W-1:0] codepoint;
  logic [PROD_W-1:0]        prod_a;
  logic [PROD_W-1:0]        prod_b;
  logic [PROD_W-1:0]        prod_c;
  logic [PROD_W-1:0]        prod_d;
  logic [DIVIDEND_W-1:0]    dividend0;
  logic [DIVIDEND_W-1:0]    dividend1;
  logic [SYM_W-1:0]         rem0;
  logic [SYM_W-1:0]         rem1;
  logic [MOD_W-1:0]         trial0;
  logic [MOD_W-1:0]         trial1;
  logic [STEP_W-1:0]        step;
  logic                     last_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= hill_pkg::MODULUS_RESET;
      key_a   <= hill_pkg::KEY_A_RESET;
      key_b   <= hill_pkg::KEY_B_RESET;
      key_c   <= hill_pkg::KEY_C_RESET;
      key_d   <= hill_pkg::KEY_D_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        hill_pkg::CFG_MODULUS:   modulus <= cfg.data;
        hill_pkg::CFG_INV_KEY_A: key_a   <= cfg.data[SYM_W-1:0];
        hill_pkg::CFG_INV_KEY_B: key_b   <= cfg.data[SYM_W-1:0];
        hill_pkg::CFG_INV_KEY_C: key_c   <= cfg.data[SYM_W-1:0];
        hill_pkg::CFG_INV_KEY_D: key_d   <= cfg.data[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (modulus == '0) begin
      eff_mod = MOD_W'(1);
    end else if (modulus > MOD_W'(hill_pkg::ALPHABET_MAX)) begin
      eff_mod = MOD_W'(hill_pkg::ALPHABET_MAX);
    end else begin
      eff_mod = modulus;
    end
  end

  assign last_step = (step == STEP_W'(hill_pkg::DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      hill_pkg::S_IDLE: begin
        if (head.valid) begin
          state_next = (head.op.kind == hill_pkg::OP_PASS) ? hill_pkg::S_PASS : hill_pkg::S_MUL;
        end
      end
      hill_pkg::S_MUL:   state_next = hill_pkg::S_SUM;
      hill_pkg::S_SUM:   state_next = hill_pkg::S_DIV;
      hill_pkg::S_DIV: begin
        if (last_step) begin
          state_next = hill_pkg::S_EMIT0;
        end
      end
      hill_pkg::S_EMIT0: begin
        if (out_ready) begin
          state_next = hill_pkg::S_EMIT1;
        end
      end
      hill_pkg::S_EMIT1, hill_pkg::S_PASS: begin
        if (out_ready) begin
          state_next = hill_pkg::S_IDLE;
        end
      end
      default: state_next = hill_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop             = 1'b0;
    out_valid       = 1'b0;
    is_passthrough  = 1'b0;
    plain_index     = '0;
    plain_codepoint = '0;
    last            = 1'b0;
    unique case (state)
      hill_pkg::S_IDLE: pop = head.valid;
      hill_pkg::S_EMIT0: begin
        out_valid   = 1'b1;
        plain_index = rem0;
      end
      hill_pkg::S_EMIT1: begin
        out_valid   = 1'b1;
        plain_index = rem1;
        last        = 1'b1;
      end
      hill_pkg::S_PASS: begin
        out_valid       = 1'b1;
        is_passthrough  = 1'b1;
        plain_codepoint = codepoint;
        last            = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hill_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign trial0 = {rem0, dividend0[DIVIDEND_W-1]};
  assign trial1 = {rem1, dividend1[DIVIDEND_W-1]};

  always_ff @(posedge clk) begin
    unique case (state)
      hill_pkg::S_IDLE: begin
        x0        <= head.op.x0;
        x1        <= head.op.x1;
        codepoint <= head.op.codepoint;
      end
      hill_pkg::S_MUL: begin
        prod_a <= key_a * x0;
        prod_b <= key_b * x0;
        prod_c <= key_c * x1;
        prod_d <= key_d * x1;
      end
      hill_pkg::S_SUM: begin
        dividend0 <= DIVIDEND_W'(prod_a) + DIVIDEND_W'(prod_c);
        dividend1 <= DIVIDEND_W'(prod_b) + DIVIDEND_W'(prod_d);
        rem0      <= '0;
        rem1      <= '0;
        step      <= '0;
      end
      hill_pkg::S_DIV: begin
        dividend0 <= {dividend0[DIVIDEND_W-2:0], 1'b0};
        dividend1 <= {dividend1[DIVIDEND_W-2:0], 1'b0};
        rem0      <= (trial0 >= eff_mod) ? SYM_W'(trial0 - eff_mod) : SYM_W'(trial0);
        rem1      <= (trial1 >= eff_mod) ? SYM_W'(trial1 - eff_mod) : SYM_W'(trial1);
        step      <= step + STEP_W'(1);
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/hill_port_watch.sv @@
// Port-level assertions for the Hill decryption stream unit and their binding.
`include "hill_2x2_decrypt_stream_unit_macros.svh"

module hill_port_watch (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         is_passthrough,
  input logic [hill_pkg::SYM_W-1:0]   plain_index,
  input logic [hill_pkg::CP_W-1:0]    plain_codepoint,
  input logic                         last
);

  `HILL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(plain_index) && $stable(plain_codepoint) && $stable(last), "result changed while stalled")
  `HILL_ASSERT_SAME(a_pass_shape, out_valid && is_passthrough, last && (plain_index == '0), "passthrough result malformed")
  `HILL_ASSERT_SAME(a_pair_shape, out_valid && !is_passthrough, plain_codepoint == '0, "decrypted result carries a codepoint")
  `HILL_ASSERT_NEXT(a_pair_second, out_valid && out_ready && !is_passthrough && !last, out_valid && !is_passthrough && last, "second result of a pair missing")

endmodule

bind hill_2x2_decrypt_stream_unit hill_port_watch u_port_watch (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .is_passthrough (is_passthrough),
  .plain_index    (plain_index),
  .plain_codepoint(plain_codepoint),
  .last           (last)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the streaming 2x2 Hill cipher decryption unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hill_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 229;
  localparam int NUM_PHASES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct packed {
    logic             passthrough;
    logic [SYM_W-1:0] index;
    logic [CP_W-1:0]  codepoint;
    logic             last;
  } plain_result_t;

  class hill_scoreboard;
    logic [MOD_W-1:0] modulus;
    logic [SYM_W-1:0] key_a, key_b, key_c, key_d;
    logic [SYM_W-1:0] held_symbol;
    bit               holding;
    plain_result_t    plain_q[$];
    int               mismatches;
    int               n_passthrough;
    int               n_decrypted;

    function new();
      modulus = MODULUS_RESET;
      key_a = KEY_A_RESET;
      key_b = KEY_B_RESET;
      key_c = KEY_C_RESET;
      key_d = KEY_D_RESET;
      held_symbol = '0;
      holding = 1'b0;
      mismatches = 0;
      n_passthrough = 0;
      n_decrypted = 0;
    endfunction

    function int unsigned eff_modulus();
      int unsigned m;
      m = modulus;
      if (m == 0) m = 1;
      if (m > ALPHABET_MAX) m = ALPHABET_MAX;
      return m;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODULUS:   modulus = data;
        CFG_INV_KEY_A: key_a = data[SYM_W-1:0];
        CFG_INV_KEY_B: key_b = data[SYM_W-1:0];
        CFG_INV_KEY_C: key_c = data[SYM_W-1:0];
        CFG_INV_KEY_D: key_d = data[SYM_W-1:0];
        default: ;
      endcase
    endfunction

    function void decrypt_pair(logic [SYM_W-1:0] x0, logic [SYM_W-1:0] x1);
      int unsigned m, y0, y1;
      plain_result_t r;
      m = eff_modulus();
      y0 = (int'(key_a) * int'(x0) + int'(key_c) * int'(x1)) % m;
      y1 = (int'(key_b) * int'(x0) + int'(key_d) * int'(x1)) % m;
      r = '{passthrough: 1'b0, index: y0[SYM_W-1:0], codepoint: '0, last: 1'b0};
      plain_q.push_back(r);
      r = '{passthrough: 1'b0, index: y1[SYM_W-1:0], codepoint: '0, last: 1'b1};
      plain_q.push_back(r);
      holding = 1'b0;
    endfunction

    function void decrypt_item(command_t cmd, logic alpha, logic [SYM_W-1:0] sym,
                               logic [CP_W-1:0] cp);
      plain_result_t r;
      if (cmd == CMD_FLUSH) begin
        if (holding) decrypt_pair(held_symbol, '0);
      end else if (!alpha) begin
        r = '{passthrough: 1'b1, index: '0, codepoint: cp, last: 1'b1};
        plain_q.push_back(r);
      end else if (!holding) begin
        held_symbol = sym;
        holding = 1'b1;
      end else begin
        decrypt_pair(held_symbol, sym);
      end
    endfunction

    function void check_result(logic pass, logic [SYM_W-1:0] idx, logic [CP_W-1:0] cp,
                               logic lst);
      plain_result_t exp_r;
      plain_result_t act_r;
      act_r = '{passthrough: pass, index: idx, codepoint: cp, last: lst};
      if (plain_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] unexpected result: pass=%0b index=%0d codepoint=%h last=%0b",
                   $realtime, pass, idx, cp, lst);
        mismatches++;
        return;
      end
      exp_r = plain_q.pop_front();
      if (pass) n_passthrough++;
      else n_decrypted++;
      if (act_r !== exp_r) begin
        if (mismatches < MAX_REPORTS)
          $display({"[%0t] mismatch: expected pass=%0b index=%0d codepoint=%h last=%0b,",
                    " got pass=%0b index=%0d codepoint=%h last=%0b"}, $realtime,
                   exp_r.passthrough, exp_r.index, exp_r.codepoint, exp_r.last,
                   pass, idx, cp, lst);
        mismatches++;
      end
    endfunction

    function int pending();
      return plain_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  command = 1'b0;
  logic                  in_alphabet = 1'b0;
  logic [SYM_W-1:0]      symbol_index = '0;
  logic [CP_W-1:0]       raw_codepoint = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  is_passthrough;
  logic [SYM_W-1:0]      plain_index;
  logic [CP_W-1:0]       plain_codepoint;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hill_scoreboard sb = new();
  int items_sent = 0;
  int hold_token = 0;

  hill_2x2_decrypt_stream_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .in_alphabet(in_alphabet),
    .symbol_index(symbol_index), .raw_codepoint(raw_codepoint),
    .out_valid(out_valid), .out_ready(out_ready),
    .is_passthrough(is_passthrough), .plain_index(plain_index),
    .plain_codepoint(plain_codepoint), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(is_passthrough, plain_index, plain_codepoint, last);
  end

  // The receiver cycles through stall patterns and honors long hold-off requests.
  initial begin
    int rx_cycle;
    int stall_left;
    int hold_seen;
    rx_cycle = 0;
    stall_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        stall_left = LONG_STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) < 7);
          2: out_ready <= ($urandom_range(0, 9) < 3);
          default: out_ready <= ((rx_cycle % 5) != 0);
        endcase
      end
    end
  end

  task automatic send_item(command_t cmd, logic alpha, logic [SYM_W-1:0] sym,
                           logic [CP_W-1:0] cp);
    in_valid <= 1'b1;
    command <= cmd;
    in_alphabet <= alpha;
    symbol_index <= sym;
    raw_codepoint <= cp;
    do @(posedge clk); while (!in_ready);
    sb.decrypt_item(cmd, alpha, sym, cp);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] m, logic [CFG_DATA_W-1:0] a,
                            logic [CFG_DATA_W-1:0] b, logic [CFG_DATA_W-1:0] c,
                            logic [CFG_DATA_W-1:0] d);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_MODULUS, m);
    write_reg(CFG_INV_KEY_A, a);
    write_reg(CFG_INV_KEY_B, b);
    write_reg(CFG_INV_KEY_C, c);
    write_reg(CFG_INV_KEY_D, d);
  endtask

  function automatic logic [CP_W-1:0] rand_codepoint();
    if ($urandom_range(0, 3) == 0) return CP_W'($urandom_range(0, 21'h1FFFFF));
    return CP_W'($urandom_range(0, 21'h10FFFF));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 9'd255;
      2: return 9'h1FF;
      default: return CFG_DATA_W'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic run_random_phase(int n_items, bit with_hold, bit with_drain);
    int burst_left;
    int gap;
    int kind;
    int unsigned eff;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (with_hold && i == n_items / 3) hold_token++;
      if (with_drain && i == n_items / 2) wait_drain();
      kind = $urandom_range(0, 99);
      eff = sb.eff_modulus();
      if (kind < 6)
        send_item(CMD_FLUSH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  rand_codepoint());
      else if (kind < 26)
        send_item(CMD_SYMBOL, 1'b0, 8'($urandom_range(0, 255)), rand_codepoint());
      else if (kind < 32)
        send_item(CMD_SYMBOL, 1'b1, 8'($urandom_range(0, 255)), rand_codepoint());
      else
        send_item(CMD_SYMBOL, 1'b1, 8'($urandom_range(0, eff - 1)), rand_codepoint());
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] mod_list[NUM_PHASES];
    mod_list = '{9'd256, 9'd0, 9'd2, 9'd511, 9'd1, 9'd255, 9'd257, 9'd26};
    mod_list[NUM_PHASES-1] = CFG_DATA_W'($urandom_range(3, 300));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items under the reset key: identity matrix, modulus 26.
    send_item(CMD_FLUSH, 1'b1, 8'hFF, 21'h1FFFFF);
    send_item(CMD_SYMBOL, 1'b1, 8'd0, 21'h0);
    send_item(CMD_SYMBOL, 1'b0, 8'd0, 21'h0);
    send_item(CMD_SYMBOL, 1'b0, 8'hFF, 21'h1FFFFF);
    send_item(CMD_SYMBOL, 1'b1, 8'd25, 21'h0);
    send_item(CMD_SYMBOL, 1'b1, 8'd25, 21'h0);
    send_item(CMD_FLUSH, 1'b0, 8'h55, 21'h0AAAAA);
    send_item(CMD_FLUSH, 1'b1, 8'h00, 21'h0);
    send_item(CMD_SYMBOL, 1'b1, 8'd255, 21'h15555);
    send_item(CMD_SYMBOL, 1'b1, 8'd200, 21'h0);

    set_config(9'd256, 9'd255, 9'd255, 9'd255, 9'd255);
    send_item(CMD_SYMBOL, 1'b1, 8'd255, 21'h0);
    send_item(CMD_SYMBOL, 1'b1, 8'd255, 21'h0);
    send_item(CMD_SYMBOL, 1'b1, 8'd0, 21'h0);
    send_item(CMD_SYMBOL, 1'b1, 8'd0, 21'h0);
    send_item(CMD_SYMBOL, 1'b1, 8'd128, 21'h0);
    send_item(CMD_FLUSH, 1'b1, 8'd0, 21'h0);

    set_config(9'd0, 9'd7, 9'd3, 9'd11, 9'd5);
    send_item(CMD_SYMBOL, 1'b1, 8'd77, 21'h0);
    send_item(CMD_SYMBOL, 1'b1, 8'd5, 21'h0);

    set_config(9'd511, 9'h1FF, 9'h100, 9'h1FF, 9'h101);
    write_reg(CFG_UNUSED_IDX, 9'h1AA);
    send_item(CMD_SYMBOL, 1'b1, 8'd255, 21'h0);
    send_item(CMD_SYMBOL, 1'b1, 8'd1, 21'h0);
    send_item(CMD_SYMBOL, 1'b0, 8'd0, 21'h10FFFF);
    send_item(CMD_SYMBOL, 1'b1, 8'd3, 21'h0);
    send_item(CMD_FLUSH, 1'b1, 8'd0, 21'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(mod_list[p], rand_key(), rand_key(), rand_key(), rand_key());
      run_random_phase(PHASE_ITEMS, p == 2, p == 5);
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
      sb.mismatches++;
    end
    $display("Run covered %0d input items over %0d key settings.", items_sent, NUM_PHASES + 4);
    $display("Checked %0d passthrough and %0d decrypted results, %0d mismatches.",
             sb.n_passthrough, sb.n_decrypted, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d results still expected", sb.pending());
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/hill_pkg.sv
hdl/hill_front.sv
hdl/hill_queue.sv
hdl/hill_back.sv
hdl/hill_2x2_decrypt_stream_unit.sv
hdl/hill_port_watch.sv
tb/tb_top.sv
